/* rtl/stt_pkg.sv */
// Shared types and constants for the source text tokenizer.
// Holds the transfer payloads, byte classes, token kinds and the keyword table.
// No dependencies.
`default_nettype none

package stt_pkg;

  // Fixed widths of the result fields
  localparam int KIND_W = 6;
  localparam int LINE_W = 20;
  localparam int COL_W  = 16;
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 16;
  localparam int ERR_W  = 2;

  // Queue depths between and after the scanner stages
  localparam int REC_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // Input transfer
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_source;
  } in_t;

  // Result transfer
  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [LINE_W-1:0] token_line;
    logic [COL_W-1:0]  token_column;
    logic [OFF_W-1:0]  token_offset;
    logic [LEN_W-1:0]  token_length;
    logic [ERR_W-1:0]  error_code;
    logic              last_of_run;
  } res_t;

  // Byte classes as seen by the scanner
  typedef enum logic [3:0] {
    CL_SPACE,
    CL_LF,
    CL_DIGIT,
    CL_ALPHA,
    CL_QUOTE,
    CL_SINGLE,
    CL_SLASH,
    CL_LT,
    CL_GT,
    CL_EQ,
    CL_BANG,
    CL_OTHER
  } char_class_e;

  // Classified byte handed from the front end to the scanner
  typedef struct packed {
    logic              is_end;
    char_class_e       cls;
    logic [KIND_W-1:0] sym_kind;
    logic [7:0]        char_byte;
  } rec_ctrl_t;

  // Token kinds (keywords are 0 to 11, their table index)
  localparam logic [KIND_W-1:0] K_NUMBER = 6'd12;
  localparam logic [KIND_W-1:0] K_STRING = 6'd13;
  localparam logic [KIND_W-1:0] K_IDENT  = 6'd14;
  localparam logic [KIND_W-1:0] K_LPAREN = 6'd15;
  localparam logic [KIND_W-1:0] K_RPAREN = 6'd16;
  localparam logic [KIND_W-1:0] K_LBRACE = 6'd17;
  localparam logic [KIND_W-1:0] K_RBRACE = 6'd18;
  localparam logic [KIND_W-1:0] K_SEMI   = 6'd19;
  localparam logic [KIND_W-1:0] K_COMMA  = 6'd20;
  localparam logic [KIND_W-1:0] K_PLUS   = 6'd21;
  localparam logic [KIND_W-1:0] K_MINUS  = 6'd22;
  localparam logic [KIND_W-1:0] K_STAR   = 6'd23;
  localparam logic [KIND_W-1:0] K_SLASH  = 6'd24;
  localparam logic [KIND_W-1:0] K_LE     = 6'd25;
  localparam logic [KIND_W-1:0] K_LT     = 6'd26;
  localparam logic [KIND_W-1:0] K_GE     = 6'd27;
  localparam logic [KIND_W-1:0] K_GT     = 6'd28;
  localparam logic [KIND_W-1:0] K_EQEQ   = 6'd29;
  localparam logic [KIND_W-1:0] K_ASSIGN = 6'd30;
  localparam logic [KIND_W-1:0] K_NE     = 6'd31;
  localparam logic [KIND_W-1:0] K_END    = 6'd32;
  localparam logic [KIND_W-1:0] K_ERROR  = 6'd33;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_STRING = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BANG   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BYTE   = 2'd3;

  // Keyword table, left-justified and space padded
  localparam int KW_NUM    = 12;
  localparam int KW_MAXLEN = 7;

  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_NUM] = '{
    "fn     ", "return ", "returns", "if     ", "else   ", "for    ",
    "print  ", "true   ", "false  ", "int    ", "bool   ", "str    "
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd2, 4'd6, 4'd7, 4'd2, 4'd4, 4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd4, 4'd3
  };

  // Keyword lookup: all twelve compares run in parallel, lowest index wins
  function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_MAXLEN-1:0][7:0] w,
                                                input logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] kind;
    logic              hit;
    kind = K_IDENT;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      hit = (len == LEN_W'(KW_LEN[i]));
      for (int j = 0; j < KW_MAXLEN; j++) begin
        if ((j < int'(KW_LEN[i])) && (w[j] != KW_TEXT[i][8*(KW_MAXLEN-1-j) +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KIND_W'(i);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

/* rtl/source_text_tokenizer_core.sv */
// Source text tokenizer, top level. An accepted byte is registered in the byte queue;
// the scanner then takes it and writes its results into the result queue.
// Throughput: one byte per cycle while the result queue has two free slots; results
// leave one per cycle; a byte that closes a token and starts a symbol yields two results.
// Reset: asynchronous, active low; queues empty, scanner idle, line 1, column 1, offset 0.
// Depends on stt_pkg, stt_front, stt_fifo and stt_back.
`default_nettype none

module source_text_tokenizer_core #(
  parameter int LINE_BITS       = 20,
  parameter int COL_BITS        = 16,
  parameter int OFFSET_BITS     = 24,
  parameter int KEYWORD_MAX_LEN = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire stt_pkg::in_t  in_data_i,
  output logic               empty,
  input  wire logic          pop,
  output stt_pkg::res_t      out_data_o
);

  import stt_pkg::*;

  localparam int REC_W = $bits(rec_ctrl_t) + LINE_BITS + COL_BITS + OFFSET_BITS;
  localparam int RQCW  = $clog2(REC_DEPTH + 1);

  logic                   acc;
  rec_ctrl_t              f_rec, b_rec;
  logic [LINE_BITS-1:0]   f_line, b_line;
  logic [COL_BITS-1:0]    f_col, b_col;
  logic [OFFSET_BITS-1:0] f_off, b_off;
  logic [REC_W-1:0]       rec_rd;
  logic                   rec_empty, rec_full, rec_pop;
  logic [RQCW-1:0]        rec_cnt;

  // Input transfer
  assign acc  = push && !rec_full;
  assign full = rec_full;

  stt_front #(
    .LINE_BITS   (LINE_BITS),
    .COL_BITS    (COL_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (in_data_i),
    .rec_o  (f_rec),
    .line_o (f_line),
    .col_o  (f_col),
    .off_o  (f_off)
  );

  // Classified bytes wait here for the scanner
  stt_fifo #(
    .DEPTH (REC_DEPTH),
    .WIDTH (REC_W)
  ) u_rec_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr0_en_i   (acc),
    .wr0_data_i ({f_rec, f_line, f_col, f_off}),
    .wr1_en_i   (1'b0),
    .wr1_data_i ({f_rec, f_line, f_col, f_off}),
    .rd_en_i    (rec_pop),
    .rd_data_o  (rec_rd),
    .empty_o    (rec_empty),
    .full_o     (rec_full),
    .count_o    (rec_cnt)
  );

  assign {b_rec, b_line, b_col, b_off} = rec_rd;

  stt_back #(
    .LINE_BITS       (LINE_BITS),
    .COL_BITS        (COL_BITS),
    .OFFSET_BITS     (OFFSET_BITS),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (rec_empty),
    .rec_i       (b_rec),
    .rline_i     (b_line),
    .rcol_i      (b_col),
    .roff_i      (b_off),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (out_data_o)
  );

  // Checks
  a_full_matches_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_full |-> (rec_cnt == RQCW'(REC_DEPTH)))
    else $error("byte queue full flag out of step with its count");

endmodule

`default_nettype wire

/* rtl/stt_fifo.sv */
// Small register queue with two write ports and one read port.
// Used between front end and scanner, and for the result queue. No dependencies.
`default_nettype none

module stt_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr0_en_i,
  input  wire logic [WIDTH-1:0]               wr0_data_i,
  input  wire logic                           wr1_en_i,
  input  wire logic [WIDTH-1:0]               wr1_data_i,
  input  wire logic                           rd_en_i,
  output logic      [WIDTH-1:0]               rd_data_o,
  output logic                                empty_o,
  output logic                                full_o,
  output logic      [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d, wp1;
  logic [CW-1:0]    cnt_q, cnt_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Pointer and fill count update
  always_comb begin
    wp1  = ptr_inc(wp_q);
    wp_d = wp_q;
    if (wr0_en_i && wr1_en_i) begin
      wp_d = ptr_inc(wp1);
    end else if (wr0_en_i) begin
      wp_d = wp1;
    end
    rp_d  = rd_en_i ? ptr_inc(rp_q) : rp_q;
    cnt_d = cnt_q + CW'(wr0_en_i) + CW'(wr0_en_i && wr1_en_i) - CW'(rd_en_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage; second write goes to the slot after the first
  always_ff @(posedge clk_i) begin
    if (wr0_en_i) begin
      mem_q[wp_q] <= wr0_data_i;
    end
    if (wr0_en_i && wr1_en_i) begin
      mem_q[wp1] <= wr1_data_i;
    end
  end

  assign rd_data_o = mem_q[rp_q];
  assign empty_o   = (cnt_q == '0);
  assign full_o    = (cnt_q == CW'(DEPTH));
  assign count_o   = cnt_q;

  // Checks
  a_no_read_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> (cnt_q != '0))
    else $error("read from empty queue");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CW'(DEPTH)))
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

/* rtl/stt_front.sv */
// Front end: classifies each source byte and tracks line, column and offset.
// Depends on stt_pkg.
`default_nettype none

module stt_front #(
  parameter int LINE_BITS   = 20,
  parameter int COL_BITS    = 16,
  parameter int OFFSET_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   acc_i,
  input  wire stt_pkg::in_t           item_i,
  output stt_pkg::rec_ctrl_t          rec_o,
  output logic      [LINE_BITS-1:0]   line_o,
  output logic      [COL_BITS-1:0]    col_o,
  output logic      [OFFSET_BITS-1:0] off_o
);

  import stt_pkg::*;

  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COL_BITS-1:0]    col_q, col_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;

  function automatic char_class_e classify(input logic [7:0] b);
    char_class_e cl;
    case (b) inside
      8'h20, 8'h09, 8'h0D:                   cl = CL_SPACE;
      8'h0A:                                 cl = CL_LF;
      [8'h30:8'h39]:                         cl = CL_DIGIT;
      [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F:   cl = CL_ALPHA;
      8'h22:                                 cl = CL_QUOTE;
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3B,
      8'h2C, 8'h2B, 8'h2D, 8'h2A:            cl = CL_SINGLE;
      8'h2F:                                 cl = CL_SLASH;
      8'h3C:                                 cl = CL_LT;
      8'h3E:                                 cl = CL_GT;
      8'h3D:                                 cl = CL_EQ;
      8'h21:                                 cl = CL_BANG;
      default:                               cl = CL_OTHER;
    endcase
    return cl;
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    case (b)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h3B:   k = K_SEMI;
      8'h2C:   k = K_COMMA;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      default: k = K_STAR;
    endcase
    return k;
  endfunction

  // Classified record, tagged with the position of this byte
  always_comb begin
    rec_o.is_end    = item_i.end_of_source;
    rec_o.cls       = classify(item_i.char_byte);
    rec_o.sym_kind  = single_kind(item_i.char_byte);
    rec_o.char_byte = item_i.char_byte;
  end

  assign line_o = line_q;
  assign col_o  = col_q;
  assign off_o  = off_q;

  // Saturating position counters; end marker restarts them
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    off_d  = off_q;
    if (item_i.end_of_source) begin
      line_d = LINE_BITS'(1);
      col_d  = COL_BITS'(1);
      off_d  = '0;
    end else begin
      if (item_i.char_byte == 8'h0A) begin
        line_d = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
        col_d  = COL_BITS'(1);
      end else begin
        col_d  = (col_q == '1) ? col_q : col_q + COL_BITS'(1);
      end
      off_d = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LINE_BITS'(1);
      col_q  <= COL_BITS'(1);
      off_q  <= '0;
    end else if (acc_i) begin
      line_q <= line_d;
      col_q  <= col_d;
      off_q  <= off_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/stt_back.sv */
// Back end: scanner state machine, keyword match and result queue.
// Depends on stt_pkg and stt_fifo.
`default_nettype none

module stt_back #(
  parameter int LINE_BITS       = 20,
  parameter int COL_BITS        = 16,
  parameter int OFFSET_BITS     = 24,
  parameter int KEYWORD_MAX_LEN = 7
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   rec_empty_i,
  input  wire stt_pkg::rec_ctrl_t     rec_i,
  input  wire logic [LINE_BITS-1:0]   rline_i,
  input  wire logic [COL_BITS-1:0]    rcol_i,
  input  wire logic [OFFSET_BITS-1:0] roff_i,
  output logic                        rec_pop_o,
  input  wire logic                   pop_i,
  output logic                        empty_o,
  output stt_pkg::res_t               res_o
);

  import stt_pkg::*;

  localparam int IDXW = (KEYWORD_MAX_LEN > 1) ? $clog2(KEYWORD_MAX_LEN) : 1;
  localparam int RCW  = $clog2(RES_DEPTH + 1);

  // Scanner modes
  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_NUMBER  = 4'd1;
  localparam logic [3:0] MODE_IDENT   = 4'd2;
  localparam logic [3:0] MODE_STRING  = 4'd3;
  localparam logic [3:0] MODE_COMMENT = 4'd4;
  localparam logic [3:0] MODE_SLASH   = 4'd5;
  localparam logic [3:0] MODE_LT      = 4'd6;
  localparam logic [3:0] MODE_GT      = 4'd7;
  localparam logic [3:0] MODE_EQ      = 4'd8;
  localparam logic [3:0] MODE_BANG    = 4'd9;

  logic [3:0]             mode_q, mode_d;
  logic                   err_q, err_d;
  logic [LINE_BITS-1:0]   sl_q, sl_d;
  logic [COL_BITS-1:0]    sc_q, sc_d;
  logic [OFFSET_BITS-1:0] so_q, so_d;
  logic [LEN_W-1:0]       len_q, len_d, len_inc;
  logic [7:0]             word_q [KEYWORD_MAX_LEN];
  logic                   word_we;
  logic [IDXW-1:0]        word_idx;
  logic [KW_MAXLEN-1:0][7:0] kw_word;

  logic                   take;
  logic [RCW-1:0]         res_cnt;
  logic                   res_full;

  // Pending-token flush values
  logic                   f_pend;
  logic [KIND_W-1:0]      f_kind;
  logic [LEN_W-1:0]       f_len;
  logic [ERR_W-1:0]       f_err;

  // Result A: pending token at its start position; result B: at this byte
  logic                   a_v, b_v, do_start, flush_start;
  logic [KIND_W-1:0]      a_kind, b_kind;
  logic [LEN_W-1:0]       a_len, b_len;
  logic [ERR_W-1:0]       a_err, b_err;
  res_t                   res_a, res_b;
  logic                   wr0_en, wr1_en;
  logic                   is_alnum;

  // Take a record only when two result slots are free
  assign take      = !rec_empty_i && (res_cnt <= RCW'(RES_DEPTH - 2));
  assign rec_pop_o = take;

  always_comb begin
    for (int k = 0; k < KW_MAXLEN; k++) begin
      kw_word[k] = word_q[k];
    end
  end

  assign len_inc  = (len_q == '1) ? len_q : len_q + LEN_W'(1);
  assign is_alnum = (rec_i.cls == CL_DIGIT) || (rec_i.cls == CL_ALPHA);

  // What the pending token turns into when something else arrives
  always_comb begin
    f_pend = 1'b1;
    f_kind = K_ERROR;
    f_len  = LEN_W'(1);
    f_err  = ERR_NONE;
    case (mode_q)
      MODE_NUMBER: begin
        f_kind = K_NUMBER;
        f_len  = len_q;
      end
      MODE_IDENT: begin
        f_kind = kw_kind(kw_word, len_q);
        f_len  = len_q;
      end
      MODE_SLASH:  f_kind = K_SLASH;
      MODE_LT:     f_kind = K_LT;
      MODE_GT:     f_kind = K_GT;
      MODE_EQ:     f_kind = K_ASSIGN;
      MODE_BANG:   f_err  = ERR_BANG;
      MODE_STRING: begin
        f_err = ERR_STRING;
        f_len = len_q;
      end
      default:     f_pend = 1'b0;
    endcase
  end

  // Scanner step for one record
  always_comb begin
    mode_d      = mode_q;
    err_d       = err_q;
    sl_d        = sl_q;
    sc_d        = sc_q;
    so_d        = so_q;
    len_d       = len_q;
    word_we     = 1'b0;
    word_idx    = len_q[IDXW-1:0];
    a_v         = 1'b0;
    a_kind      = f_kind;
    a_len       = f_len;
    a_err       = f_err;
    b_v         = 1'b0;
    b_kind      = K_END;
    b_len       = '0;
    b_err       = ERR_NONE;
    do_start    = 1'b0;
    flush_start = 1'b0;

    if (take) begin
      if (rec_i.is_end) begin
        // Flush, end token, back to the start state
        a_v    = !err_q && f_pend;
        b_v    = 1'b1;
        mode_d = MODE_IDLE;
        err_d  = 1'b0;
        sl_d   = LINE_BITS'(1);
        sc_d   = COL_BITS'(1);
        so_d   = '0;
        len_d  = '0;
      end else if (!err_q) begin
        case (mode_q)
          MODE_NUMBER: begin
            if (rec_i.cls == CL_DIGIT) begin
              len_d = len_inc;
            end else begin
              flush_start = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_alnum) begin
              word_we = (len_q < LEN_W'(KEYWORD_MAX_LEN));
              len_d   = len_inc;
            end else begin
              flush_start = 1'b1;
            end
          end
          MODE_STRING: begin
            if (rec_i.cls == CL_QUOTE) begin
              a_v    = 1'b1;
              a_kind = K_STRING;
              a_len  = len_q;
              a_err  = ERR_NONE;
              mode_d = MODE_IDLE;
            end else begin
              len_d = len_inc;
            end
          end
          MODE_COMMENT: begin
            if (rec_i.cls == CL_LF) begin
              mode_d = MODE_IDLE;
            end
          end
          MODE_SLASH: begin
            if (rec_i.cls == CL_SLASH) begin
              mode_d = MODE_COMMENT;
            end else begin
              flush_start = 1'b1;
            end
          end
          MODE_LT, MODE_GT, MODE_EQ, MODE_BANG: begin
            if (rec_i.cls == CL_EQ) begin
              // Two-character operator
              a_v    = 1'b1;
              a_len  = LEN_W'(2);
              a_err  = ERR_NONE;
              mode_d = MODE_IDLE;
              case (mode_q)
                MODE_LT: a_kind = K_LE;
                MODE_GT: a_kind = K_GE;
                MODE_EQ: a_kind = K_EQEQ;
                default: a_kind = K_NE;
              endcase
            end else if (mode_q == MODE_BANG) begin
              // Lone bang: error, no restart
              a_v    = 1'b1;
              err_d  = 1'b1;
              mode_d = MODE_IDLE;
            end else begin
              flush_start = 1'b1;
            end
          end
          default: do_start = 1'b1;
        endcase

        if (flush_start) begin
          a_v      = 1'b1;
          do_start = 1'b1;
        end

        // Start of a new token from this byte
        if (do_start) begin
          mode_d = MODE_IDLE;
          if ((rec_i.cls != CL_SPACE) && (rec_i.cls != CL_LF)) begin
            sl_d  = rline_i;
            sc_d  = rcol_i;
            so_d  = roff_i;
            len_d = LEN_W'(1);
          end
          case (rec_i.cls)
            CL_DIGIT: mode_d = MODE_NUMBER;
            CL_ALPHA: begin
              word_we  = 1'b1;
              word_idx = '0;
              mode_d   = MODE_IDENT;
            end
            CL_QUOTE: begin
              so_d   = (roff_i == '1) ? roff_i : roff_i + OFFSET_BITS'(1);
              len_d  = '0;
              mode_d = MODE_STRING;
            end
            CL_SINGLE: begin
              b_v    = 1'b1;
              b_kind = rec_i.sym_kind;
              b_len  = LEN_W'(1);
            end
            CL_SLASH: mode_d = MODE_SLASH;
            CL_LT:    mode_d = MODE_LT;
            CL_GT:    mode_d = MODE_GT;
            CL_EQ:    mode_d = MODE_EQ;
            CL_BANG:  mode_d = MODE_BANG;
            CL_OTHER: begin
              b_v    = 1'b1;
              b_kind = K_ERROR;
              b_len  = LEN_W'(1);
              b_err  = ERR_BYTE;
              err_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      err_q  <= 1'b0;
      sl_q   <= LINE_BITS'(1);
      sc_q   <= COL_BITS'(1);
      so_q   <= '0;
      len_q  <= '0;
    end else begin
      mode_q <= mode_d;
      err_q  <= err_d;
      sl_q   <= sl_d;
      sc_q   <= sc_d;
      so_q   <= so_d;
      len_q  <= len_d;
    end
  end

  // Leading identifier bytes for the keyword compare
  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_q[word_idx] <= rec_i.char_byte;
    end
  end

  // Pack results; A goes first when both are present
  always_comb begin
    res_a.token_kind   = a_kind;
    res_a.token_line   = LINE_W'(sl_q);
    res_a.token_column = COL_W'(sc_q);
    res_a.token_offset = OFF_W'(so_q);
    res_a.token_length = a_len;
    res_a.error_code   = a_err;
    res_a.last_of_run  = !b_v;

    res_b.token_kind   = b_kind;
    res_b.token_line   = LINE_W'(rline_i);
    res_b.token_column = COL_W'(rcol_i);
    res_b.token_offset = OFF_W'(roff_i);
    res_b.token_length = b_len;
    res_b.error_code   = b_err;
    res_b.last_of_run  = 1'b1;
  end

  assign wr0_en = a_v || b_v;
  assign wr1_en = a_v && b_v;

  stt_fifo #(
    .DEPTH (RES_DEPTH),
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr0_en_i   (wr0_en),
    .wr0_data_i (a_v ? res_a : res_b),
    .wr1_en_i   (wr1_en),
    .wr1_data_i (res_b),
    .rd_en_i    (pop_i && !empty_o),
    .rd_data_o  (res_o),
    .empty_o    (empty_o),
    .full_o     (res_full),
    .count_o    (res_cnt)
  );

  // Checks
  a_silent_after_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && err_q && !rec_i.is_end) |-> !(a_v || b_v))
    else $error("result produced while error is latched");

  a_end_emits_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && rec_i.is_end) |=> (!empty_o && !err_q && (mode_q == MODE_IDLE)))
    else $error("end marker did not restart the scanner");

  a_no_pop_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full |-> !take)
    else $error("scanner took a record with no result space");

endmodule

`default_nettype wire

/* test/source_text_tokenizer_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for source_text_tokenizer_core: byte stream in, tokens out.
// Drives directed and random source text; a built-in lexer predicts every token.
// Depends on stt_pkg and source_text_tokenizer_core.

module source_text_tokenizer_core_test;
  import stt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_BYTES   = 260;
  localparam int LONG_WORD      = 40;
  localparam int WORD_MAX       = 7;
  localparam int KW_COUNT       = 12;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [LINE_W-1:0] LINE_TOP = '1;
  localparam logic [COL_W-1:0]  COL_TOP  = '1;
  localparam logic [OFF_W-1:0]  OFF_TOP  = '1;
  localparam logic [LEN_W-1:0]  LEN_TOP  = '1;

  typedef enum logic [3:0] {
    SM_IDLE, SM_NUMBER, SM_IDENT, SM_STRING, SM_COMMENT,
    SM_SLASH, SM_LT, SM_GT, SM_EQ, SM_BANG
  } scan_mode_e;

  // Keyword spellings, in token kind order
  string kw_words [KW_COUNT] = '{"fn", "return", "returns", "if", "else", "for",
                                 "print", "true", "false", "int", "bool", "str"};
  string op_words [8] = '{"<=", "<", ">=", ">", "==", "=", "!=", "/"};
  string single_syms = "(){};,+-*";

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  in_t  in_data_i = '0;
  logic full;
  logic empty;
  res_t out_data_o;

  source_text_tokenizer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Test state shared between processes
  in_t  feed [$];
  res_t tokens_due [$];
  bit   steady = 1'b0;
  bit   armed = 1'b0;
  int   hold_asks = 0;
  int   fails = 0;
  int   bytes_taken = 0;
  int   tokens_checked = 0;
  int   error_tokens = 0;
  int   full_stalls = 0;
  int   queued = 0;

  // Lexer state of the predictor
  scan_mode_e        mode = SM_IDLE;
  logic [LINE_W-1:0] line_now = 1, tok_line = 1;
  logic [COL_W-1:0]  col_now = 1, tok_col = 1;
  logic [OFF_W-1:0]  off_now = 0, tok_off = 0;
  logic [LEN_W-1:0]  tok_len = 0;
  logic [7:0]        word_buf [WORD_MAX];
  bit                error_held = 1'b0;
  res_t              step_res [$];

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void lexer_clear();
    mode = SM_IDLE;
    line_now = 1; col_now = 1; off_now = 0;
    tok_line = 1; tok_col = 1; tok_off = 0; tok_len = 0;
    error_held = 1'b0;
  endfunction

  // At most two tokens per byte
  function automatic void emit_token(logic [KIND_W-1:0] kind, logic [LINE_W-1:0] ln,
                                     logic [COL_W-1:0] cl, logic [OFF_W-1:0] of,
                                     logic [LEN_W-1:0] len, logic [ERR_W-1:0] err);
    res_t r;
    if (step_res.size() < 2) begin
      r.token_kind   = kind;
      r.token_line   = ln;
      r.token_column = cl;
      r.token_offset = of;
      r.token_length = len;
      r.error_code   = err;
      r.last_of_run  = 1'b0;
      step_res = {step_res, r};
    end
  endfunction

  function automatic void emit_pending(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len);
    emit_token(kind, tok_line, tok_col, tok_off, len, ERR_NONE);
  endfunction

  function automatic void raise_err(logic [ERR_W-1:0] code, logic [LINE_W-1:0] ln,
                                    logic [COL_W-1:0] cl, logic [OFF_W-1:0] of,
                                    logic [LEN_W-1:0] len);
    emit_token(K_ERROR, ln, cl, of, len, code);
    error_held = 1'b1;
    mode = SM_IDLE;
  endfunction

  function automatic void bump_len();
    if (tok_len != LEN_TOP) tok_len++;
  endfunction

  // Keyword match on the first bytes of a short word
  function automatic logic [KIND_W-1:0] word_kind();
    bit hit;
    if (tok_len > WORD_MAX) return K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (kw_words[i].len() == tok_len);
      for (int j = 0; hit && j < kw_words[i].len(); j++) begin
        if (kw_words[i][j] != word_buf[j]) hit = 1'b0;
      end
      if (hit) return KIND_W'(i);
    end
    return K_IDENT;
  endfunction

  // Report whatever token is open
  function automatic void close_token(bit at_end);
    case (mode)
      SM_NUMBER: emit_pending(K_NUMBER, tok_len);
      SM_IDENT:  emit_pending(word_kind(), tok_len);
      SM_SLASH:  emit_pending(K_SLASH, 1);
      SM_LT:     emit_pending(K_LT, 1);
      SM_GT:     emit_pending(K_GT, 1);
      SM_EQ:     emit_pending(K_ASSIGN, 1);
      SM_BANG:   raise_err(ERR_BANG, tok_line, tok_col, tok_off, 1);
      SM_STRING: if (at_end) raise_err(ERR_STRING, tok_line, tok_col, tok_off, tok_len);
      default: ;
    endcase
    mode = SM_IDLE;
  endfunction

  function automatic void open_token(logic [7:0] c);
    if (c == CH_LF || c == CH_SP || c == CH_CR || c == CH_TAB) return;
    tok_line = line_now;
    tok_col  = col_now;
    tok_off  = off_now;
    tok_len  = 1;
    if (is_digit(c)) begin
      mode = SM_NUMBER;
    end else if (is_alpha(c)) begin
      word_buf[0] = c;
      mode = SM_IDENT;
    end else if (c == "\"") begin
      tok_off = (off_now != OFF_TOP) ? off_now + 1'b1 : off_now;
      tok_len = 0;
      mode = SM_STRING;
    end else begin
      case (c)
        "(": emit_pending(K_LPAREN, 1);
        ")": emit_pending(K_RPAREN, 1);
        "{": emit_pending(K_LBRACE, 1);
        "}": emit_pending(K_RBRACE, 1);
        ";": emit_pending(K_SEMI, 1);
        ",": emit_pending(K_COMMA, 1);
        "+": emit_pending(K_PLUS, 1);
        "-": emit_pending(K_MINUS, 1);
        "*": emit_pending(K_STAR, 1);
        "/": mode = SM_SLASH;
        "<": mode = SM_LT;
        ">": mode = SM_GT;
        "=": mode = SM_EQ;
        "!": mode = SM_BANG;
        default: raise_err(ERR_BYTE, line_now, col_now, off_now, 1);
      endcase
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    case (mode)
      SM_NUMBER: begin
        if (is_digit(c)) bump_len();
        else begin
          close_token(1'b0);
          open_token(c);
        end
      end
      SM_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (tok_len < WORD_MAX) word_buf[tok_len] = c;
          bump_len();
        end else begin
          close_token(1'b0);
          open_token(c);
        end
      end
      SM_STRING: begin
        if (c == "\"") begin
          emit_pending(K_STRING, tok_len);
          mode = SM_IDLE;
        end else bump_len();
      end
      SM_COMMENT: if (c == CH_LF) mode = SM_IDLE;
      SM_SLASH: begin
        if (c == "/") mode = SM_COMMENT;
        else begin
          close_token(1'b0);
          open_token(c);
        end
      end
      SM_LT, SM_GT, SM_EQ, SM_BANG: begin
        if (c == "=") begin
          case (mode)
            SM_LT:   emit_pending(K_LE, 2);
            SM_GT:   emit_pending(K_GE, 2);
            SM_EQ:   emit_pending(K_EQEQ, 2);
            default: emit_pending(K_NE, 2);
          endcase
          mode = SM_IDLE;
        end else begin
          close_token(1'b0);
          if (!error_held) open_token(c);
        end
      end
      default: open_token(c);
    endcase
  endfunction

  // Tokens caused by one accepted transfer, queued in order
  function automatic void lex_transfer(in_t x);
    step_res.delete();
    if (x.end_of_source) begin
      if (!error_held) close_token(1'b1);
      emit_token(K_END, line_now, col_now, off_now, 0, ERR_NONE);
      lexer_clear();
    end else begin
      if (!error_held) scan_byte(x.char_byte);
      if (x.char_byte == CH_LF) begin
        if (line_now != LINE_TOP) line_now++;
        col_now = 1;
      end else if (col_now != COL_TOP) begin
        col_now++;
      end
      if (off_now != OFF_TOP) off_now++;
    end
    if (step_res.size() != 0) step_res[step_res.size() - 1].last_of_run = 1'b1;
    foreach (step_res[i]) tokens_due = {tokens_due, step_res[i]};
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endfunction

  // Sender: offers the next queued byte, holds it while the block is full
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        lex_transfer(in_data_i);
        bytes_taken++;
      end
      if (push && full) begin
        full_stalls++;
      end else if (feed.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        push      <= 1'b1;
        in_data_i <= feed.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: checks each token transfer, with random and requested hold-offs
  always @(posedge clk_i) begin : token_monitor
    res_t exp_r;
    int   hold_left;
    int   hold_done;
    if (rst_ni) begin
      if (pop && !empty) begin
        tokens_checked++;
        if (out_data_o.token_kind == K_ERROR) error_tokens++;
        if (tokens_due.size() == 0) begin
          $error("token_kind: expected nothing, got %0d", out_data_o.token_kind);
          fails++;
        end else begin
          exp_r = tokens_due.pop_front();
          check_field("token_kind", exp_r.token_kind, out_data_o.token_kind);
          check_field("token_line", exp_r.token_line, out_data_o.token_line);
          check_field("token_column", exp_r.token_column, out_data_o.token_column);
          check_field("token_offset", exp_r.token_offset, out_data_o.token_offset);
          check_field("token_length", exp_r.token_length, out_data_o.token_length);
          check_field("error_code", exp_r.error_code, out_data_o.error_code);
          check_field("last_of_run", exp_r.last_of_run, out_data_o.last_of_run);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (armed) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
        $display("source_text_tokenizer_core regression: fail");
        $finish;
      end else begin
        quiet++;
      end
    end
  end

  // Source text builders
  task automatic put_byte(logic [7:0] b);
    in_t x;
    x.char_byte     = b;
    x.end_of_source = 1'b0;
    feed = {feed, x};
    queued++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // End marker; its byte is don't-care, so randomise it
  task automatic put_end();
    in_t x;
    x.char_byte     = 8'($urandom_range(0, 255));
    x.end_of_source = 1'b1;
    feed = {feed, x};
    queued++;
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 5) == 0) return 8'("0" + $urandom_range(0, 9));
    return rand_alpha();
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic put_random_token();
    logic [7:0] b;
    int n;
    case ($urandom_range(0, 9))
      0, 1: put_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
      2, 3: begin
        n = $urandom_range(1, 10);
        put_byte(rand_alpha());
        repeat (n - 1) put_byte(rand_alnum());
      end
      4: repeat ($urandom_range(1, 6)) put_byte(8'("0" + $urandom_range(0, 9)));
      5: begin
        put_byte("\"");
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 3) == 0) begin
            do b = 8'($urandom_range(0, 255)); while (b == "\"");
          end else begin
            do b = 8'($urandom_range(32, 126)); while (b == "\"");
          end
          put_byte(b);
        end
        put_byte("\"");
      end
      6: put_byte(single_syms[$urandom_range(0, 8)]);
      7: put_text(op_words[$urandom_range(0, 7)]);
      8: begin
        put_text("//");
        repeat ($urandom_range(0, 10)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
          put_byte(b);
        end
        put_byte(CH_LF);
      end
      default: repeat ($urandom_range(1, 3)) put_byte(rand_space());
    endcase
  endtask

  // Broken input: stray byte, lone bang, or a string left open
  task automatic put_noise();
    case ($urandom_range(0, 2))
      0: put_byte(8'($urandom_range(0, 255)));
      1: put_text("! ");
      default: put_text("\"open");
    endcase
  endtask

  task automatic put_program();
    repeat ($urandom_range(3, 30)) begin
      if ($urandom_range(0, 39) == 0) put_noise();
      else put_random_token();
      if ($urandom_range(0, 1) == 0) put_byte(rand_space());
    end
    put_end();
  endtask

  // Sender pause: nothing more until every expected token has come back
  task automatic wait_drained();
    do @(negedge clk_i); while (feed.size() != 0 || push || tokens_due.size() != 0);
  endtask

  initial begin
    int rand_base;
    lexer_clear();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    armed  = 1'b1;

    // Keywords, near-keywords, numbers
    put_text("fn return returns if else for print true false int bool str\n");
    put_text("returnsx retur Return _ z9_ 0 007 1234567890\n");
    put_end();
    // Symbols, operators, comments, adjacent tokens
    put_text("(){};,+-*/ <= < >= > == = != a/b // note (\n");
    put_byte(CH_TAB);
    put_byte(CH_CR);
    put_text("x<y>=z!=w==v=u;f(g)//");
    put_end();
    // Strings with a newline inside, empty string, odd bytes inside text
    put_text("\"ab\ncd\" \"\" \"");
    put_byte(8'hFF);
    put_byte(8'h00);
    put_text("\" // ");
    put_byte(8'h80);
    put_end();
    // Pending tokens flushed by the end marker
    put_text("x = y/");  put_end();
    put_text("a<");      put_end();
    put_text("b>");      put_end();
    put_text("c=");      put_end();
    put_text("d!");      put_end();
    put_text("12");      put_end();
    put_text("abc");     put_end();
    put_end();
    // Errors, then silence until the end marker
    put_text("a ! b c d\n"); put_end();
    put_text("k ");  put_byte(8'hFF); put_text(" m n"); put_end();
    put_byte(8'h80); put_end();
    put_byte(8'h00); put_end();
    put_text("@ 1"); put_end();
    put_text("q \"open\nstring"); put_end();
    wait_drained();

    // Receiver holds off while the sender keeps offering two-token bytes
    hold_asks++;
    repeat (6) put_text("a(b)c;d{e}f,g+h-i*j;");
    put_end();
    wait_drained();

    // One long identifier, no gaps on either side
    steady = 1'b1;
    put_byte(rand_alpha());
    repeat (LONG_WORD - 1) put_byte(rand_alnum());
    put_text(" = 1;\n x");
    put_end();
    wait_drained();
    steady = 1'b0;

    // Random programs
    rand_base = queued;
    while (queued - rand_base < RANDOM_BYTES) put_program();
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d bytes and end markers, %0d tokens checked, %0d of them errors.",
             bytes_taken, tokens_checked, error_tokens);
    $display("Input held off by a full block in %0d cycles; one word ran past keyword length.",
             full_stalls);
    if (fails == 0) begin
      $display("source_text_tokenizer_core regression: pass");
    end else begin
      $display("source_text_tokenizer_core regression: fail");
    end
    $finish;
  end

endmodule
